[hw/rtl/ssw_pkg.sv]
// Shared types and constants for the segment substring window block.
// Used by the channel interfaces, the register file, the divider cells,
// the bounds pipeline and the top level.
package ssw_pkg;

	// Field widths
	localparam int LEN_W  = 12;
	localparam int SEG_W  = 5;
	localparam int THR_W  = 4;
	localparam int MCNT_W = 5;
	localparam int CNT_W  = 6;
	localparam int DIFF_W = LEN_W + 1;
	localparam int CAND_W = LEN_W + 3;
	localparam int PROD_W = LEN_W + SEG_W;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Limits of the scheme
	localparam logic [LEN_W-1:0] MAX_LENGTH   = 12'd4095;
	localparam logic [CNT_W-1:0] MAX_SEGMENTS = 6'd32;

	// Register indexes, one register per 32-bit word
	typedef enum logic {
		REG_EDIT_THRESHOLD = 1'b0,
		REG_MATCH_COUNT    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0]  edit_threshold;
		logic [MCNT_W-1:0] match_count;
	} cfg_t;

	// Item as it travels down the divider chain
	typedef struct packed {
		logic [LEN_W-1:0] probe_length;
		logic [LEN_W-1:0] partner_length;
		logic [SEG_W-1:0] segment_number;
		logic [CNT_W-1:0] seg_count;
		logic [LEN_W-1:0] dividend;
		logic [CNT_W-1:0] rem;
		logic [LEN_W-1:0] quot;
	} div_t;

	typedef struct packed {
		logic [LEN_W-1:0] first_position;
		logic [LEN_W-1:0] last_position;
		logic [LEN_W-1:0] substring_length;
		logic [LEN_W-1:0] segment_start;
		logic             window_empty;
		logic             bad_request;
	} result_t;

endpackage

[hw/rtl/ssw_ifs.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on ssw_pkg for field widths.
interface ssw_req_if;
	logic                           valid;
	logic                           ready;
	logic [ssw_pkg::LEN_W-1:0]      probe_length;
	logic [ssw_pkg::LEN_W-1:0]      partner_length;
	logic [ssw_pkg::SEG_W-1:0]      segment_number;

	modport source (output valid, output probe_length, output partner_length,
		output segment_number, input ready);
	modport sink (input valid, input probe_length, input partner_length,
		input segment_number, output ready);
endinterface

interface ssw_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [ssw_pkg::LEN_W-1:0]      first_position;
	logic [ssw_pkg::LEN_W-1:0]      last_position;
	logic [ssw_pkg::LEN_W-1:0]      substring_length;
	logic [ssw_pkg::LEN_W-1:0]      segment_start;
	logic                           window_empty;
	logic                           bad_request;

	modport source (output valid, output first_position, output last_position,
		output substring_length, output segment_start, output window_empty,
		output bad_request, input ready);
	modport sink (input valid, input first_position, input last_position,
		input substring_length, input segment_start, input window_empty,
		input bad_request, output ready);
endinterface

[hw/rtl/ssw_regs.sv]
// APB-style register file: edit threshold and match count.
// Depends on ssw_pkg.
module ssw_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssw_pkg::ADDR_W-1:0]  paddr,
	input  logic [ssw_pkg::DATA_W-1:0]  pwdata,
	output logic [ssw_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output ssw_pkg::cfg_t               cfg
);

	logic [ssw_pkg::THR_W-1:0]  thr_q;
	logic [ssw_pkg::MCNT_W-1:0] mcnt_q;
	logic                       wr_en;
	ssw_pkg::reg_idx_t          idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = ssw_pkg::reg_idx_t'(paddr[2]);

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= 4'd1;
			mcnt_q <= 5'd2;
		end else if (wr_en) begin
			unique case (idx)
				ssw_pkg::REG_EDIT_THRESHOLD: thr_q  <= pwdata[ssw_pkg::THR_W-1:0];
				ssw_pkg::REG_MATCH_COUNT:    mcnt_q <= pwdata[ssw_pkg::MCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			ssw_pkg::REG_EDIT_THRESHOLD: prdata[ssw_pkg::THR_W-1:0]  = thr_q;
			ssw_pkg::REG_MATCH_COUNT:    prdata[ssw_pkg::MCNT_W-1:0] = mcnt_q;
			default: prdata = '0;
		endcase
	end

	assign cfg.edit_threshold = thr_q;
	assign cfg.match_count    = mcnt_q;

endmodule

[hw/rtl/ssw_div_cell.sv]
// One cell of the divider chain: resolves one quotient bit of
// partner_length / segment count and hands the item to the next cell.
// Depends on ssw_pkg.
module ssw_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ssw_pkg::div_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ssw_pkg::div_t out_data
);

	logic                       valid_q;
	ssw_pkg::div_t              data_q;
	ssw_pkg::div_t              next;
	logic [ssw_pkg::CNT_W:0]    trial;
	logic [ssw_pkg::CNT_W:0]    diff;
	logic                       take;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {in_data.rem, in_data.dividend[ssw_pkg::LEN_W-1]};
		diff  = trial - {1'b0, in_data.seg_count};
		take  = (trial >= {1'b0, in_data.seg_count});
		next  = in_data;
		next.rem      = take ? diff[ssw_pkg::CNT_W-1:0] : trial[ssw_pkg::CNT_W-1:0];
		next.quot     = {in_data.quot[ssw_pkg::LEN_W-2:0], take};
		next.dividend = {in_data.dividend[ssw_pkg::LEN_W-2:0], 1'b0};
	end

	// Advance when empty or when the neighbor takes the held item
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

[hw/rtl/ssw_bounds.sv]
// Four-stage pipeline after the divider chain: segment length, segment
// start, window bound candidates, then clamped window and flags.
// Depends on ssw_pkg.
module ssw_bounds (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ssw_pkg::div_t    in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output ssw_pkg::result_t out_data
);

	localparam int PADC = ssw_pkg::CAND_W - ssw_pkg::LEN_W;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// Stage 1 registers
	logic                          bad_s1;
	logic [ssw_pkg::LEN_W-1:0]     len_s1;
	logic [ssw_pkg::CNT_W-1:0]     off_s1;
	logic [ssw_pkg::SEG_W-1:0]     seg_s1;
	logic [ssw_pkg::CNT_W-1:0]     ext_s1;
	logic [ssw_pkg::LEN_W-1:0]     probe_s1;
	logic signed [ssw_pkg::DIFF_W-1:0] diff_s1;

	// Stage 2 registers
	logic                          bad_s2;
	logic [ssw_pkg::LEN_W-1:0]     len_s2;
	logic [ssw_pkg::LEN_W-1:0]     start_s2;
	logic [ssw_pkg::SEG_W-1:0]     seg_s2;
	logic [ssw_pkg::CNT_W-1:0]     ext_s2;
	logic [ssw_pkg::LEN_W-1:0]     probe_s2;
	logic signed [ssw_pkg::DIFF_W-1:0] diff_s2;

	// Stage 3 registers
	logic                          bad_s3;
	logic [ssw_pkg::LEN_W-1:0]     len_s3;
	logic [ssw_pkg::LEN_W-1:0]     start_s3;
	logic signed [ssw_pkg::CAND_W-1:0] lo_a_s3, lo_b_s3, hi_a_s3, hi_b_s3, hi_c_s3;

	ssw_pkg::result_t res_s4;

	// Stage 1 logic
	logic [ssw_pkg::CNT_W-1:0] seg_ext, n_minus_d;
	logic                      bad_c, long_c;

	// Stage 2 and 3 logic
	logic [ssw_pkg::PROD_W-1:0]        prod;
	logic [ssw_pkg::PROD_W-1:0]        start_full;
	logic signed [ssw_pkg::CAND_W-1:0] s_x, seg_x, ext_x, diff_x, probe_x, len_x;

	// Stage 4 logic
	logic signed [ssw_pkg::CAND_W-1:0] lo_m, first_c, last_m, last_c;
	ssw_pkg::result_t                  res_c;

	// Per-stage flow control: a stage moves when empty or its successor moves
	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Stage 1: flag bad requests, pick the longer segments, segment length
	always_comb begin
		seg_ext   = {1'b0, in_data.segment_number};
		n_minus_d = in_data.seg_count - in_data.rem;
		bad_c     = (in_data.seg_count == '0) ||
			(in_data.seg_count > ssw_pkg::MAX_SEGMENTS) ||
			(seg_ext >= in_data.seg_count) ||
			(in_data.partner_length <
				{{(ssw_pkg::LEN_W-ssw_pkg::CNT_W){1'b0}}, in_data.seg_count});
		long_c    = (seg_ext >= n_minus_d);
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			bad_s1   <= bad_c;
			len_s1   <= in_data.quot + {{(ssw_pkg::LEN_W-1){1'b0}}, long_c};
			off_s1   <= long_c ? n_minus_d : '0;
			seg_s1   <= in_data.segment_number;
			ext_s1   <= in_data.seg_count - seg_ext - 6'd1;
			probe_s1 <= in_data.probe_length;
			diff_s1  <= $signed({1'b0, in_data.probe_length}) -
				$signed({1'b0, in_data.partner_length});
		end
	end

	// Stage 2: segment start = index * length - shift of the longer segments
	assign prod = {{ssw_pkg::LEN_W{1'b0}}, seg_s1} * {{ssw_pkg::SEG_W{1'b0}}, len_s1};
	assign start_full = prod - {{(ssw_pkg::PROD_W-ssw_pkg::CNT_W){1'b0}}, off_s1};

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			bad_s2   <= bad_s1;
			len_s2   <= len_s1;
			start_s2 <= start_full[ssw_pkg::LEN_W-1:0];
			seg_s2   <= seg_s1;
			ext_s2   <= ext_s1;
			probe_s2 <= probe_s1;
			diff_s2  <= diff_s1;
		end
	end

	// Stage 3: lower and upper bound candidates, signed
	always_comb begin
		s_x     = $signed({{PADC{1'b0}}, start_s2});
		seg_x   = $signed({{(ssw_pkg::CAND_W-ssw_pkg::SEG_W){1'b0}}, seg_s2});
		ext_x   = $signed({{(ssw_pkg::CAND_W-ssw_pkg::CNT_W){1'b0}}, ext_s2});
		diff_x  = {{(ssw_pkg::CAND_W-ssw_pkg::DIFF_W){diff_s2[ssw_pkg::DIFF_W-1]}}, diff_s2};
		probe_x = $signed({{PADC{1'b0}}, probe_s2});
		len_x   = $signed({{PADC{1'b0}}, len_s2});
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			bad_s3   <= bad_s2;
			len_s3   <= len_s2;
			start_s3 <= start_s2;
			lo_a_s3  <= s_x - seg_x;
			lo_b_s3  <= s_x + diff_x - ext_x;
			hi_a_s3  <= probe_x - len_x;
			hi_b_s3  <= s_x + seg_x;
			hi_c_s3  <= s_x + diff_x + ext_x;
		end
	end

	// Stage 4: take max of lower bounds, min of upper bounds, clamp at zero
	always_comb begin
		lo_m    = (lo_a_s3 > lo_b_s3) ? lo_a_s3 : lo_b_s3;
		first_c = lo_m[ssw_pkg::CAND_W-1] ? '0 : lo_m;
		last_m  = (hi_a_s3 < hi_b_s3) ? hi_a_s3 : hi_b_s3;
		last_m  = (hi_c_s3 < last_m) ? hi_c_s3 : last_m;
		last_c  = last_m[ssw_pkg::CAND_W-1] ? '0 : last_m;
		if (bad_s3) begin
			res_c              = '0;
			res_c.window_empty = 1'b1;
			res_c.bad_request  = 1'b1;
		end else begin
			res_c.first_position   = first_c[ssw_pkg::LEN_W-1:0];
			res_c.last_position    = last_c[ssw_pkg::LEN_W-1:0];
			res_c.substring_length = len_s3;
			res_c.segment_start    = start_s3;
			res_c.window_empty     = (last_m < first_c);
			res_c.bad_request      = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			res_s4 <= res_c;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = res_s4;

endmodule

[hw/rtl/segment_substring_window.sv]
// Top level of the segment substring window block: register file,
// twelve-cell divider chain and bounds pipeline.
// Depends on ssw_pkg, ssw_ifs, ssw_regs, ssw_div_cell and ssw_bounds.
//
//  channel | kind           | direction | carries
//  --------+----------------+-----------+-------------------------------------------
//  req     | valid/ready    | in        | probe_length, partner_length, segment_number
//  rsp     | valid/ready    | out       | first/last_position, substring_length,
//          |                |           | segment_start, window_empty, bad_request
//  apb     | APB-style      | in        | edit_threshold @0x0, match_count @0x4
//
// One item per cycle while rsp is not stalled; each item takes one quotient bit per cell
// in the divider chain (12 cells), then passes through the bounds pipeline.
// arst_n empties every stage and loads edit_threshold = 1, match_count = 2.
// Every stage holds its item while the one after it is full and stalled, so
// empty stages keep filling and requests are still taken during a result stall.
module segment_substring_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssw_pkg::ADDR_W-1:0]  paddr,
	input  logic [ssw_pkg::DATA_W-1:0]  pwdata,
	output logic [ssw_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	ssw_req_if.sink                     req,
	ssw_rsp_if.source                   rsp
);

	localparam int CELLS = ssw_pkg::LEN_W;

	ssw_pkg::cfg_t     cfg;
	ssw_pkg::div_t     head;
	ssw_pkg::result_t  res;
	logic [ssw_pkg::LEN_W-1:0] probe_sat, partner_sat;

	logic              chain_valid [CELLS+1];
	logic              chain_ready [CELLS+1];
	ssw_pkg::div_t     chain_data  [CELLS+1];

	ssw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Saturate lengths and build the chain head with segment count n = t + k
	always_comb begin
		probe_sat   = (req.probe_length > ssw_pkg::MAX_LENGTH) ?
			ssw_pkg::MAX_LENGTH : req.probe_length;
		partner_sat = (req.partner_length > ssw_pkg::MAX_LENGTH) ?
			ssw_pkg::MAX_LENGTH : req.partner_length;
		head.probe_length   = probe_sat;
		head.partner_length = partner_sat;
		head.segment_number = req.segment_number;
		head.seg_count      = {2'b00, cfg.edit_threshold} + {1'b0, cfg.match_count};
		head.dividend       = partner_sat;
		head.rem            = '0;
		head.quot           = '0;
	end

	assign chain_valid[0] = req.valid;
	assign chain_data[0]  = head;
	assign req.ready      = chain_ready[0];

	// Divider chain, one quotient bit per cell
	for (genvar j = 0; j < CELLS; j++) begin : g_cell
		ssw_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[j]),
			.in_ready  (chain_ready[j]),
			.in_data   (chain_data[j]),
			.out_valid (chain_valid[j+1]),
			.out_ready (chain_ready[j+1]),
			.out_data  (chain_data[j+1])
		);
	end

	ssw_bounds u_bounds (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[CELLS]),
		.in_ready  (chain_ready[CELLS]),
		.in_data   (chain_data[CELLS]),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (res)
	);

	assign rsp.first_position   = res.first_position;
	assign rsp.last_position    = res.last_position;
	assign rsp.substring_length = res.substring_length;
	assign rsp.segment_start    = res.segment_start;
	assign rsp.window_empty     = res.window_empty;
	assign rsp.bad_request      = res.bad_request;

endmodule

[hw/rtl/ssw_checker.sv]
// Port-level checks for segment_substring_window, attached by bind.
// Depends on ssw_pkg and the top level's ports.
module ssw_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pready,
	input  logic                       rsp_valid,
	input  logic                       rsp_ready,
	input  logic [ssw_pkg::LEN_W-1:0]  first_position,
	input  logic [ssw_pkg::LEN_W-1:0]  last_position,
	input  logic [ssw_pkg::LEN_W-1:0]  substring_length,
	input  logic [ssw_pkg::LEN_W-1:0]  segment_start,
	input  logic                       window_empty,
	input  logic                       bad_request
);

	// Stalled result holds its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable({first_position,
			last_position, substring_length, segment_start, window_empty, bad_request}))
		else $error("result changed while stalled");

	// Refused request reports an empty, zeroed window
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bad_request |-> window_empty && first_position == '0 &&
			last_position == '0 && substring_length == '0 && segment_start == '0)
		else $error("bad request with nonzero window");

	// Nonempty window is ordered
	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !bad_request && !window_empty |-> first_position <= last_position)
		else $error("nonempty window out of order");

	// Segment lies inside a partner of legal length
	a_segment_fits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !bad_request |->
			({1'b0, segment_start} + {1'b0, substring_length}) <=
			{1'b0, ssw_pkg::MAX_LENGTH})
		else $error("segment runs past the maximum length");

	// Configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind segment_substring_window ssw_checker u_ssw_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.pready           (pready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.first_position   (rsp.first_position),
	.last_position    (rsp.last_position),
	.substring_length (rsp.substring_length),
	.segment_start    (rsp.segment_start),
	.window_empty     (rsp.window_empty),
	.bad_request      (rsp.bad_request)
);

[tb/sv/tb_segment_substring_window.sv]
`timescale 1ns / 1ps
// Self-checking testbench for segment_substring_window: drives requests and APB
// register writes, predicts each segment window and checks every result transfer.
// Depends on ssw_pkg, ssw_ifs and the segment_substring_window RTL.
module tb_segment_substring_window;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 21;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 200;
	localparam int PHASES       = 9;

	// Thresholds and item counts per random phase; -1 picks random thresholds
	localparam int PHASE_THR [PHASES]   = '{0, 15, 15, 0, 15, 3, 7, -1, 1};
	localparam int PHASE_MCNT [PHASES]  = '{1, 16, 17, 0, 31, 5, 9, -1, 2};
	localparam int PHASE_ITEMS [PHASES] = '{130, 130, 130, 40, 40, 150, 130, 130, 130};

	typedef struct packed {
		logic [ssw_pkg::LEN_W-1:0] probe_length;
		logic [ssw_pkg::LEN_W-1:0] partner_length;
		logic [ssw_pkg::SEG_W-1:0] segment_number;
	} request_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [ssw_pkg::ADDR_W-1:0] paddr = '0;
	logic [ssw_pkg::DATA_W-1:0] pwdata = '0;
	logic [ssw_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	ssw_req_if req ();
	ssw_rsp_if rsp ();

	segment_substring_window dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req),
		.rsp     (rsp)
	);

	// Register copies for prediction
	logic [ssw_pkg::THR_W-1:0]  cfg_thr = 4'd1;
	logic [ssw_pkg::MCNT_W-1:0] cfg_mcnt = 5'd2;

	request_t          pending_requests[$];
	ssw_pkg::result_t  expected_windows[$];
	ssw_pkg::result_t  oldest_window;
	int       mismatches = 0;
	int       cycles = 0;
	int       results_seen = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;
	bit       calm = 1'b0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d, expected %0d (result %0d, t=%0d)", what, got, want,
			results_seen, cycles);
		mismatches++;
	endtask

	// Segment bounds and probe window for one request under thresholds t and k
	function automatic ssw_pkg::result_t window_of(logic [ssw_pkg::THR_W-1:0] t,
		logic [ssw_pkg::MCNT_W-1:0] k, request_t r);
		int               S, P, n, seg, q, d, i, lng, l, s, D, first, last;
		ssw_pkg::result_t w;
		S = int'(r.probe_length);
		P = int'(r.partner_length);
		seg = int'(r.segment_number);
		n = int'(t) + int'(k);
		w = '0;
		if (n == 0 || n > int'(ssw_pkg::MAX_SEGMENTS) || seg >= n || P < n) begin
			w.window_empty = 1'b1;
			w.bad_request = 1'b1;
			return w;
		end
		q = P / n;
		d = P - q * n;
		i = seg + 1;
		lng = (i > n - d) ? 1 : 0;
		l = q + lng;
		s = (i - 1) * l - lng * (n - d);
		D = S - P;
		first = s - (i - 1);
		if (s + D - (n - i) > first)
			first = s + D - (n - i);
		if (first < 0)
			first = 0;
		last = S - l;
		if (s + (i - 1) < last)
			last = s + (i - 1);
		if (s + D + (n - i) < last)
			last = s + D + (n - i);
		w.window_empty = last < first;
		if (last < 0)
			last = 0;
		w.first_position = ssw_pkg::LEN_W'(first);
		w.last_position = ssw_pkg::LEN_W'(last);
		w.substring_length = ssw_pkg::LEN_W'(l);
		w.segment_start = ssw_pkg::LEN_W'(s);
		return w;
	endfunction

	// Request driver: predict on each accepted transfer, then offer the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready)
				expected_windows = {expected_windows, window_of(cfg_thr, cfg_mcnt,
					request_t'({req.probe_length, req.partner_length, req.segment_number}))};
			if (!req.valid || req.ready) begin
				if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					req.valid <= 1'b1;
					{req.probe_length, req.partner_length, req.segment_number} <=
						pending_requests.pop_front();
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold: start once enough results are in, count it down
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result monitor: check each transfer, stay off while the hold runs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (expected_windows.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					oldest_window = expected_windows.pop_front();
					if (rsp.first_position !== oldest_window.first_position)
						report_mismatch("first_position", int'(rsp.first_position),
							int'(oldest_window.first_position));
					if (rsp.last_position !== oldest_window.last_position)
						report_mismatch("last_position", int'(rsp.last_position),
							int'(oldest_window.last_position));
					if (rsp.substring_length !== oldest_window.substring_length)
						report_mismatch("substring_length", int'(rsp.substring_length),
							int'(oldest_window.substring_length));
					if (rsp.segment_start !== oldest_window.segment_start)
						report_mismatch("segment_start", int'(rsp.segment_start),
							int'(oldest_window.segment_start));
					if (rsp.window_empty !== oldest_window.window_empty)
						report_mismatch("window_empty", int'(rsp.window_empty),
							int'(oldest_window.window_empty));
					if (rsp.bad_request !== oldest_window.bad_request)
						report_mismatch("bad_request", int'(rsp.bad_request),
							int'(oldest_window.bad_request));
				end
			end
			if (hold_left > 0)
				rsp.ready <= 1'b0;
			else
				rsp.ready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL segment_substring_window");
			$finish;
		end
	end

	task automatic write_reg(ssw_pkg::reg_idx_t idx, logic [ssw_pkg::DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == ssw_pkg::REG_EDIT_THRESHOLD)
			cfg_thr = value[ssw_pkg::THR_W-1:0];
		else
			cfg_mcnt = value[ssw_pkg::MCNT_W-1:0];
	endtask

	task automatic read_reg(ssw_pkg::reg_idx_t idx);
		logic [ssw_pkg::DATA_W-1:0] want;
		want = (idx == ssw_pkg::REG_EDIT_THRESHOLD) ? ssw_pkg::DATA_W'(cfg_thr) :
			ssw_pkg::DATA_W'(cfg_mcnt);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			report_mismatch("prdata", int'(prdata), int'(want));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write both registers with junk above the field, then read them back
	task automatic set_thresholds(int t, int k);
		write_reg(ssw_pkg::REG_EDIT_THRESHOLD,
			(ssw_pkg::DATA_W'($urandom) << ssw_pkg::THR_W) | ssw_pkg::DATA_W'(t));
		write_reg(ssw_pkg::REG_MATCH_COUNT,
			(ssw_pkg::DATA_W'($urandom) << ssw_pkg::MCNT_W) | ssw_pkg::DATA_W'(k));
		read_reg(ssw_pkg::REG_EDIT_THRESHOLD);
		read_reg(ssw_pkg::REG_MATCH_COUNT);
	endtask

	// Wait until every offered item has come back, then let the pipeline settle
	task automatic drain();
		while (pending_requests.size() != 0 || req.valid || expected_windows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_request(int S, int P, int seg);
		request_t r;
		r = {ssw_pkg::LEN_W'(S), ssw_pkg::LEN_W'(P), ssw_pkg::SEG_W'(seg)};
		pending_requests = {pending_requests, r};
	endtask

	// Mostly well-formed requests near the partner length, some noise
	task automatic queue_random(int count);
		int n, P, S, seg, pick;
		n = int'(cfg_thr) + int'(cfg_mcnt);
		repeat (count) begin
			pick = $urandom_range(9);
			if (pick == 0) begin
				P = $urandom_range(4095);
				S = $urandom_range(4095);
				seg = $urandom_range(31);
			end else begin
				if (pick < 3)
					P = $urandom_range(60);
				else if (pick < 6)
					P = (n > 0 ? n : 1) + $urandom_range(200);
				else
					P = $urandom_range(4095, 1);
				S = P + $urandom_range(40) - 20;
				if (pick == 9)
					S = $urandom_range(4095);
				if (S < 0)
					S = 0;
				if (S > 4095)
					S = 4095;
				if (n > 0 && n <= int'(ssw_pkg::MAX_SEGMENTS) && $urandom_range(7) != 0)
					seg = $urandom_range(n - 1);
				else
					seg = $urandom_range(31);
			end
			queue_request(S, P, seg);
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.probe_length = '0;
		req.partner_length = '0;
		req.segment_number = '0;
		rsp.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		read_reg(ssw_pkg::REG_EDIT_THRESHOLD);
		read_reg(ssw_pkg::REG_MATCH_COUNT);

		// Directed requests under the reset thresholds (three segments)
		queue_request(3, 3, 0);
		queue_request(3, 3, 1);
		queue_request(3, 3, 2);
		queue_request(4095, 4095, 0);
		queue_request(4095, 4095, 2);
		queue_request(0, 4095, 1);
		queue_request(4095, 3, 2);
		queue_request(10, 10, 3);
		queue_request(10, 10, 31);
		queue_request(5, 0, 0);
		queue_request(5, 2, 1);
		queue_request(8, 10, 0);
		queue_request(8, 10, 1);
		queue_request(8, 10, 2);
		queue_request(12'hAAA, 12'h555, 1);
		queue_request(12'h555, 12'hAAA, 2);
		queue_request(0, 3, 0);
		queue_request(2, 5, 2);
		queue_request(1, 5, 2);
		queue_request(100, 60, 1);
		queue_request(60, 100, 1);
		queue_request(4095, 4095, 31);
		drain();

		// Random phases over a spread of thresholds, extremes included
		for (int ph = 0; ph < PHASES; ph++) begin
			if (PHASE_THR[ph] < 0)
				set_thresholds($urandom_range(15), $urandom_range(16, 1));
			else
				set_thresholds(PHASE_THR[ph], PHASE_MCNT[ph]);
			calm = (ph == 6);
			if (ph == 5) begin
				// pause mid-phase until every result is back
				queue_random(PHASE_ITEMS[ph] / 2);
				drain();
				queue_random(PHASE_ITEMS[ph] - PHASE_ITEMS[ph] / 2);
			end else begin
				queue_random(PHASE_ITEMS[ph]);
			end
			drain();
		end
		calm = 1'b0;

		if (mismatches == 0)
			$display("PASS segment_substring_window");
		else
			$display("FAIL segment_substring_window");
		$finish;
	end

endmodule
